// ===== src/pfsw_pkg.sv =====
package pfsw_pkg;

  localparam int unsigned ColorW    = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned DataW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned ColW      = 12;
  localparam int unsigned RowPixW   = 13;
  localparam int unsigned PitchW    = 16;
  localparam int unsigned DepthW    = 6;
  localparam int unsigned WidthsW   = 12;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 72;
  localparam int unsigned DefFifoDepth = 2;

  localparam logic [RowPixW-1:0] RowMax = RowPixW'(4096);

  localparam logic [DepthW-1:0] Bpp8  = DepthW'(8);
  localparam logic [DepthW-1:0] Bpp15 = DepthW'(15);
  localparam logic [DepthW-1:0] Bpp16 = DepthW'(16);
  localparam logic [DepthW-1:0] Bpp24 = DepthW'(24);
  localparam logic [DepthW-1:0] Bpp32 = DepthW'(32);

  localparam logic [CountW-1:0] Bytes1 = CountW'(1);
  localparam logic [CountW-1:0] Bytes2 = CountW'(2);
  localparam logic [CountW-1:0] Bytes3 = CountW'(3);
  localparam logic [CountW-1:0] Bytes4 = CountW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CfgPixelDepth   = 3'd0,
    CfgChanWidths   = 3'd1,
    CfgRedShift     = 3'd2,
    CfgGreenShift   = 3'd3,
    CfgBlueShift    = 3'd4,
    CfgRowPixels    = 3'd5,
    CfgRowPitch     = 3'd6,
    CfgFrameBase    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DepthW-1:0]   pixel_depth;
    logic [WidthsW-1:0]  channel_widths;
    logic [ShiftW-1:0]   red_shift;
    logic [ShiftW-1:0]   green_shift;
    logic [ShiftW-1:0]   blue_shift;
    logic [RowPixW-1:0]  row_pixels;
    logic [PitchW-1:0]   row_pitch;
    logic [AddrW-1:0]    frame_base;
  } cfg_t;

  // queued word: color channels, frame-relative byte offset, bytes per pixel
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [AddrW-1:0]  offset;
    logic [CountW-1:0] bytes;
  } entry_t;

  function automatic logic [7:0] cut_channel(input logic [7:0] v, input logic [3:0] w);
    logic [7:0] r;
    r = '0;
    if (w == 4'd0) begin
      r = '0;
    end else if (w >= 4'd8) begin
      r = v;
    end else begin
      r = v >> (4'd8 - w);
    end
    return r;
  endfunction

endpackage

// ===== src/pixel_format_scanout_writer_core.sv =====
// Converts one 0xRRGGBBAA pixel per clock into one framebuffer write word:
// a 3-3-2 index at 8 bpp, or width-cut and shifted channels at 15/16/24/32 bpp,
// with address frame_base + row offset + column * bytes per pixel. Sustained
// rate is one pixel per cycle; each pixel reaches the output by way of
// a short queue and the output register. Pixels at an unsupported
// depth are taken and dropped without advancing the position. Input stalls
// only when the queue is full because the output is backpressured.
module pixel_format_scanout_writer_core #(
  parameter int unsigned FifoDepth = pfsw_pkg::DefFifoDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfsw_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pfsw_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pfsw_pkg::InTdataW-1:0]    s_axis_tdata,  // [31:0] color_rgba
  input  logic                             s_axis_tuser,  // [0] frame_start
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] write_address, [63:32] write_data, [66:64] byte_count, rest zero
  output logic [pfsw_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import pfsw_pkg::*;

  cfg_t              cfg_q;
  entry_t            push_entry, pop_entry;
  logic              push, pop, q_full, q_empty;
  logic [AddrW-1:0]  write_address;
  logic [DataW-1:0]  write_data;
  logic [CountW-1:0] byte_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_depth    <= Bpp32;
      cfg_q.channel_widths <= WidthsW'(2184);
      cfg_q.red_shift      <= ShiftW'(16);
      cfg_q.green_shift    <= ShiftW'(8);
      cfg_q.blue_shift     <= '0;
      cfg_q.row_pixels     <= RowPixW'(640);
      cfg_q.row_pitch      <= PitchW'(2560);
      cfg_q.frame_base     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPixelDepth: cfg_q.pixel_depth    <= cfg_wdata_i[DepthW-1:0];
        CfgChanWidths: cfg_q.channel_widths <= cfg_wdata_i[WidthsW-1:0];
        CfgRedShift:   cfg_q.red_shift      <= cfg_wdata_i[ShiftW-1:0];
        CfgGreenShift: cfg_q.green_shift    <= cfg_wdata_i[ShiftW-1:0];
        CfgBlueShift:  cfg_q.blue_shift     <= cfg_wdata_i[ShiftW-1:0];
        CfgRowPixels:  cfg_q.row_pixels     <= cfg_wdata_i[RowPixW-1:0];
        CfgRowPitch:   cfg_q.row_pitch      <= cfg_wdata_i[PitchW-1:0];
        CfgFrameBase:  cfg_q.frame_base     <= cfg_wdata_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  pfsw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .color_rgba_i  (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  pfsw_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rdata_o (pop_entry)
  );

  pfsw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .entry_i         (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .write_address_o (write_address),
    .write_data_o    (write_data),
    .byte_count_o    (byte_count)
  );

  assign m_axis_tdata = {5'd0, byte_count, write_data, write_address};

endmodule

// ===== src/pfsw_front.sv =====
module pfsw_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfsw_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pfsw_pkg::ColorW-1:0] color_rgba_i,
  input  logic                       frame_start_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output pfsw_pkg::entry_t           entry_o
);
  import pfsw_pkg::*;

  logic [ColW-1:0]    col_q, col_d, col_base;
  logic [AddrW-1:0]   roff_q, roff_d, roff_base;
  logic [CountW-1:0]  bytes;
  logic               supported;
  logic               accept;
  logic [ColW+1:0]    col_bytes;
  logic [RowPixW-1:0] limit;
  logic [RowPixW-1:0] next_col;

  always_comb begin
    supported = 1'b1;
    bytes     = Bytes4;
    unique case (cfg_i.pixel_depth) inside
      Bpp8:          bytes = Bytes1;
      Bpp15, Bpp16:  bytes = Bytes2;
      Bpp24:         bytes = Bytes3;
      Bpp32:         bytes = Bytes4;
      default:       supported = 1'b0;
    endcase
  end

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept & supported;

  assign col_base  = frame_start_i ? '0 : col_q;
  assign roff_base = frame_start_i ? '0 : roff_q;

  always_comb begin
    case (bytes)
      Bytes1:  col_bytes = {2'b00, col_base};
      Bytes2:  col_bytes = {1'b0, col_base, 1'b0};
      Bytes3:  col_bytes = {2'b00, col_base} + {1'b0, col_base, 1'b0};
      default: col_bytes = {col_base, 2'b00};
    endcase
  end

  always_comb begin
    entry_o.red    = color_rgba_i[31:24];
    entry_o.green  = color_rgba_i[23:16];
    entry_o.blue   = color_rgba_i[15:8];
    entry_o.offset = roff_base + AddrW'(col_bytes);
    entry_o.bytes  = bytes;
  end

  always_comb begin
    if (cfg_i.row_pixels == '0) begin
      limit = RowPixW'(1);
    end else if (cfg_i.row_pixels > RowMax) begin
      limit = RowMax;
    end else begin
      limit = cfg_i.row_pixels;
    end
    next_col = {1'b0, col_base} + RowPixW'(1);
    col_d  = col_q;
    roff_d = roff_q;
    if (accept) begin
      col_d  = col_base;
      roff_d = roff_base;
      if (supported) begin
        if (next_col >= limit) begin
          col_d  = '0;
          roff_d = roff_base + AddrW'(cfg_i.row_pitch);
        end else begin
          col_d  = next_col[ColW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      roff_q <= '0;
    end else begin
      col_q  <= col_d;
      roff_q <= roff_d;
    end
  end

endmodule

// ===== src/pfsw_fifo.sv =====
module pfsw_fifo #(
  parameter int unsigned Depth = pfsw_pkg::DefFifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pfsw_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output pfsw_pkg::entry_t rdata_o
);
  import pfsw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not track push");

endmodule

// ===== src/pfsw_back.sv =====
module pfsw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pfsw_pkg::cfg_t               cfg_i,
  input  logic                         q_empty_i,
  input  pfsw_pkg::entry_t             entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pfsw_pkg::AddrW-1:0]   write_address_o,
  output logic [pfsw_pkg::DataW-1:0]   write_data_o,
  output logic [pfsw_pkg::CountW-1:0]  byte_count_o
);
  import pfsw_pkg::*;

  logic              valid_q;
  logic [AddrW-1:0]  addr_q;
  logic [DataW-1:0]  data_q, data_d, packed_rgb;
  logic [CountW-1:0] cnt_q;
  logic [7:0]        r_cut, g_cut, b_cut;

  assign pop_o = ~q_empty_i & (~valid_q | out_ready_i);

  always_comb begin
    r_cut = cut_channel(entry_i.red,   cfg_i.channel_widths[11:8]);
    g_cut = cut_channel(entry_i.green, cfg_i.channel_widths[7:4]);
    b_cut = cut_channel(entry_i.blue,  cfg_i.channel_widths[3:0]);
    packed_rgb = (DataW'(r_cut) << cfg_i.red_shift)
               | (DataW'(g_cut) << cfg_i.green_shift)
               | (DataW'(b_cut) << cfg_i.blue_shift);
    case (entry_i.bytes)
      Bytes1:  data_d = {24'd0, entry_i.red[7:5], entry_i.green[7:5], entry_i.blue[7:6]};
      Bytes2:  data_d = {16'd0, packed_rgb[15:0]};
      Bytes3:  data_d = {8'd0, packed_rgb[23:0]};
      default: data_d = packed_rgb;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q <= cfg_i.frame_base + entry_i.offset;
      data_q <= data_d;
      cnt_q  <= entry_i.bytes;
    end
  end

  assign out_valid_o     = valid_q;
  assign write_address_o = addr_q;
  assign write_data_o    = data_q;
  assign byte_count_o    = cnt_q;

endmodule
